// ===== hw/rtl/ias_pkg.sv =====
// shared types and codes for the indexed array store
`default_nettype none

package ias_pkg;

    // operation codes carried by each input word
    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_GET    = 3'd2,
        OP_SET    = 3'd3,
        OP_INSERT = 3'd4
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_INS_WR,
        S_DONE
    } t_state;

    // memory read address select
    typedef enum logic [1:0] {
        RA_FILL_M1,
        RA_INDEX,
        RA_PTR_M2
    } t_rsel;

    // memory write address select
    typedef enum logic [1:0] {
        WA_FILL,
        WA_INDEX,
        WA_PTR
    } t_wsel;

    // commands from controller to datapath
    typedef struct packed {
        logic    capture;
        logic    mem_wr;
        t_wsel   wr_sel;
        logic    wr_from_mem;
        logic    mem_rd;
        t_rsel   rd_sel;
        logic    fill_inc;
        logic    fill_dec;
        logic    ptr_load;
        logic    ptr_dec;
        logic    set_res;
        t_status res_status;
        logic    res_take;
        logic    load_out;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_op  op;
        logic empty;
        logic full;
        logic idx_lt_fill;
        logic idx_eq_fill;
        logic ptr_m1_eq_idx;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/ias_dpath.sv =====
// datapath of the indexed array store: item registers, element memory, count, result stage
`default_nettype none

module ias_dpath
    import ias_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic [2:0]         i_op,
    input  wire logic [4:0]         i_index,
    input  wire logic signed [31:0] i_value,
    input  wire logic               i_ready,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_read_value,
    output logic [4:0]              o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = (FW > 5) ? FW : 5;

    // captured input word
    t_op         r_op;
    logic [4:0]  r_index;
    logic [31:0] r_value;

    // element count and shift pointer
    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_ptr;

    // element memory
    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    // pending result
    t_status r_status;
    logic    r_take;

    // output stage
    logic              r_out_valid;
    logic [1:0]        r_o_status;
    logic signed [31:0] r_o_read_value;
    logic [4:0]        r_o_count;

    logic [CW-1:0] fill_ext;
    logic [CW-1:0] idx_ext;
    logic [FW-1:0] fill_m1;
    logic [FW-1:0] ptr_m1;
    logic [FW-1:0] ptr_m2;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    assign fill_ext = CW'(r_fill);
    assign idx_ext  = CW'(r_index);
    assign fill_m1  = r_fill - FW'(1);
    assign ptr_m1   = r_ptr - FW'(1);
    assign ptr_m2   = ptr_m1 - FW'(1);

    // status flags for the controller
    assign o_sts.op            = r_op;
    assign o_sts.empty         = (r_fill == '0);
    assign o_sts.full          = (r_fill == FW'(DEPTH));
    assign o_sts.idx_lt_fill   = (idx_ext < fill_ext);
    assign o_sts.idx_eq_fill   = (idx_ext == fill_ext);
    assign o_sts.ptr_m1_eq_idx = (CW'(ptr_m1) == idx_ext);
    assign o_sts.out_busy      = r_out_valid && !i_ready;

    // capture the input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= t_op'(i_op);
            r_index <= i_index;
            r_value <= i_value;
        end
    end

    // element count
    always_comb begin
        n_fill = r_fill;
        if (i_cmd.fill_inc) begin
            n_fill = r_fill + FW'(1);
        end else if (i_cmd.fill_dec) begin
            n_fill = fill_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // shift pointer walks down from the count toward the index
    always_ff @(posedge i_clk) begin
        if (i_cmd.ptr_load) begin
            r_ptr <= r_fill;
        end else if (i_cmd.ptr_dec) begin
            r_ptr <= ptr_m1;
        end
    end

    // address and data selection
    always_comb begin
        case (i_cmd.rd_sel)
            RA_FILL_M1: rd_addr = fill_m1[AW-1:0];
            RA_INDEX:   rd_addr = idx_ext[AW-1:0];
            RA_PTR_M2:  rd_addr = ptr_m2[AW-1:0];
            default:    rd_addr = fill_m1[AW-1:0];
        endcase
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WA_FILL:  wr_addr = r_fill[AW-1:0];
            WA_INDEX: wr_addr = idx_ext[AW-1:0];
            WA_PTR:   wr_addr = r_ptr[AW-1:0];
            default:  wr_addr = r_fill[AW-1:0];
        endcase
    end

    assign wr_data = i_cmd.wr_from_mem ? r_rdata : r_value;

    // memory write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // memory read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            r_status <= i_cmd.res_status;
            r_take   <= i_cmd.res_take;
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_status     <= r_status;
            r_o_read_value <= r_take ? r_rdata : 32'sd0;
            r_o_count      <= fill_ext[4:0];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_o_status;
    assign o_read_value = r_o_read_value;
    assign o_count      = r_o_count;

    // count stays within capacity
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("element count above capacity");

    // shift writes stay between the index and the count
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mem_wr && i_cmd.wr_sel == WA_PTR) |->
            (CW'(r_ptr) > idx_ext) && (r_ptr <= r_fill))
        else $error("shift write outside the moved range");

    // pop lowers the count by exactly one
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_dec |=> r_fill == $past(fill_m1))
        else $error("count not lowered by one");

    // a loaded result is presented on the next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// ===== hw/rtl/ias_ctrl.sv =====
// controller of the indexed array store: decodes the operation and sequences the insert shift
`default_nettype none

module ias_ctrl
    import ias_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.op == OP_INSERT && i_sts.idx_lt_fill && !i_sts.full) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (i_sts.ptr_m1_eq_idx) begin
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.wr_sel     = WA_FILL;
        o_cmd.rd_sel     = RA_FILL_M1;
        o_cmd.res_status = ST_OK;
        o_ready          = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.capture = i_valid;
            end
            S_EXEC: begin
                o_cmd.set_res = 1'b1;
                unique case (i_sts.op)
                    OP_PUSH: begin
                        if (i_sts.full) begin
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.mem_wr   = 1'b1;
                            o_cmd.wr_sel   = WA_FILL;
                            o_cmd.fill_inc = 1'b1;
                        end
                    end
                    OP_POP: begin
                        if (i_sts.empty) begin
                            o_cmd.res_status = ST_BOUNDS;
                        end else begin
                            o_cmd.mem_rd   = 1'b1;
                            o_cmd.rd_sel   = RA_FILL_M1;
                            o_cmd.fill_dec = 1'b1;
                            o_cmd.res_take = 1'b1;
                        end
                    end
                    OP_GET: begin
                        if (i_sts.idx_lt_fill) begin
                            o_cmd.mem_rd   = 1'b1;
                            o_cmd.rd_sel   = RA_INDEX;
                            o_cmd.res_take = 1'b1;
                        end else begin
                            o_cmd.res_status = ST_BOUNDS;
                        end
                    end
                    OP_SET: begin
                        if (i_sts.idx_lt_fill) begin
                            o_cmd.mem_wr = 1'b1;
                            o_cmd.wr_sel = WA_INDEX;
                        end else begin
                            o_cmd.res_status = ST_BOUNDS;
                        end
                    end
                    OP_INSERT: begin
                        if (!i_sts.idx_lt_fill && !i_sts.idx_eq_fill) begin
                            o_cmd.res_status = ST_BOUNDS;
                        end else if (i_sts.full) begin
                            o_cmd.res_status = ST_FULL;
                        end else if (i_sts.idx_eq_fill) begin
                            // append at the end, nothing to move
                            o_cmd.mem_wr   = 1'b1;
                            o_cmd.wr_sel   = WA_INDEX;
                            o_cmd.fill_inc = 1'b1;
                        end else begin
                            // fetch the last element and start the shift
                            o_cmd.mem_rd   = 1'b1;
                            o_cmd.rd_sel   = RA_FILL_M1;
                            o_cmd.ptr_load = 1'b1;
                        end
                    end
                    default: o_cmd.res_status = ST_BOUNDS;
                endcase
            end
            S_SHIFT: begin
                // move one element up, prefetch the next one down
                o_cmd.mem_wr      = 1'b1;
                o_cmd.wr_sel      = WA_PTR;
                o_cmd.wr_from_mem = 1'b1;
                if (!i_sts.ptr_m1_eq_idx) begin
                    o_cmd.mem_rd  = 1'b1;
                    o_cmd.rd_sel  = RA_PTR_M2;
                    o_cmd.ptr_dec = 1'b1;
                end
            end
            S_INS_WR: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.wr_sel   = WA_INDEX;
                o_cmd.fill_inc = 1'b1;
            end
            S_DONE: begin
                o_cmd.load_out = !i_sts.out_busy;
            end
            default: o_cmd = '0;
        endcase
    end

    // a new word is taken only once the previous result has been loaded into the output register
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> !o_ready)
        else $error("second word taken while one is in flight");

    // the count never moves both ways at once
    a_fill_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.fill_inc && o_cmd.fill_dec))
        else $error("count raised and lowered together");

    // a shift always finishes with the new word written at the index
    a_shift_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && i_sts.ptr_m1_eq_idx) |=> r_state == S_INS_WR)
        else $error("shift did not end in the insert write");

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_array_store.sv =====
// top level of the indexed array store: controller plus datapath
// Usage:
//   Input channel i_valid / o_ready carries one word: i_op, i_index, i_value.
//   Output channel o_valid / i_ready returns one word per input word:
//   o_status, o_read_value, o_count (elements held after the operation).
//   A word moves on a rising edge where valid and ready are both high.
// Sequence:
//   Push, pop, get, set, appends at the end and failed operations pass through
//   execute and done, the result loaded from done. Any other insert runs
//   execute, shift and insert write before done, with one write port: the
//   shift moves one element per cycle from the top down, then writes the new
//   word. The longest shift is at index 0 with DEPTH - 1 elements held.
//   A new word is taken only once the block is back in idle.
// Stall:
//   One word is in progress at a time; o_ready is high only when idle. The
//   result sits in an output register; while the receiver holds i_ready
//   low the block finishes the next word's work and waits to load it.
// Reset:
//   i_rst_n low clears the count and the output valid; element contents are
//   not cleared and are only ever read after being written.
`default_nettype none

module indexed_array_store
    import ias_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_op,
    input  wire logic [4:0]         i_index,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_read_value,
    output logic [4:0]              o_count
);

    t_cmd cmd;
    t_sts sts;

    // sequencing
    ias_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // storage and result stage
    ias_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (i_op),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_count      (o_count)
    );

endmodule

`default_nettype wire

// ===== tb/array_store_checker.sv =====
`timescale 1ns / 100ps
// reply checker for the indexed array store: shadows the array and compares every reply word

module array_store_checker
    import ias_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [2:0]  i_op,
    input  logic [4:0]  i_index,
    input  logic [31:0] i_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_read_value,
    input  logic [4:0]  i_count,
    output int          o_mismatches,
    output int          o_outstanding,
    output int          o_held,
    output int          o_replies,
    output int          o_full_hits,
    output int          o_bounds_hits
);

    typedef struct {
        logic [2:0]  op;
        t_status     status;
        logic [31:0] read_value;
        logic [4:0]  count;
    } t_reply;

    // shadow copy of the element array and its count
    logic [31:0] shadow_cells [DEPTH];
    int          held = 0;
    t_reply      pending_replies [$];
    int          mismatches = 0;
    int          replies = 0;
    int          full_hits = 0;
    int          bounds_hits = 0;

    // apply one accepted word to the shadow array and queue the reply it must produce
    task automatic predict_reply(input logic [2:0] op, input logic [4:0] idx,
                                 input logic [31:0] val);
        t_reply r;
        int     k;
        r.op = op;
        r.status = ST_OK;
        r.read_value = '0;
        case (op)
            OP_PUSH: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_cells[held] = val;
                    held++;
                end
            end
            OP_POP: begin
                if (held == 0) begin
                    r.status = ST_BOUNDS;
                end else begin
                    held--;
                    r.read_value = shadow_cells[held];
                end
            end
            OP_GET: begin
                if (int'(idx) >= held) begin
                    r.status = ST_BOUNDS;
                end else begin
                    r.read_value = shadow_cells[idx];
                end
            end
            OP_SET: begin
                if (int'(idx) >= held) begin
                    r.status = ST_BOUNDS;
                end else begin
                    shadow_cells[idx] = val;
                end
            end
            OP_INSERT: begin
                // bounds test wins over the full test
                if (int'(idx) > held) begin
                    r.status = ST_BOUNDS;
                end else if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (k = held; k > int'(idx); k--) begin
                        shadow_cells[k] = shadow_cells[k - 1];
                    end
                    shadow_cells[idx] = val;
                    held++;
                end
            end
            default: begin
                // spare op codes are refused
                r.status = ST_BOUNDS;
            end
        endcase
        r.count = 5'(held);
        if (r.status == ST_FULL) begin
            full_hits++;
        end else if (r.status == ST_BOUNDS) begin
            bounds_hits++;
        end
        pending_replies.push_back(r);
    endtask

    // watch both channels at each edge
    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            held = 0;
            pending_replies.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_reply(i_op, i_index, i_value);
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected reply word status %0d read %h count %0d",
                                 $realtime, i_status, i_read_value, i_count);
                    end
                end else begin
                    want = pending_replies.pop_front();
                    replies++;
                    if (i_status !== want.status || i_read_value !== want.read_value
                            || i_count !== want.count) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch op %0d: status %0d/%0d read %h/%h count %0d/%0d",
                                     $realtime, want.op, want.status, i_status,
                                     want.read_value, i_read_value, want.count, i_count);
                        end
                    end
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= pending_replies.size();
        o_held        <= held;
        o_replies     <= replies;
        o_full_hits   <= full_hits;
        o_bounds_hits <= bounds_hits;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// testbench top for the indexed array store: clock, reset, stimulus and verdict

module testbench;
    import ias_pkg::*;

    localparam int DEPTH = 16;
    localparam int RANDOM_WORDS = 1500;

    // op codes the block does not define
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [2:0]         i_op;
    logic [4:0]         i_index;
    logic signed [31:0] i_value;
    logic               o_valid;
    logic               i_ready;
    logic [1:0]         o_status;
    logic signed [31:0] o_read_value;
    logic [4:0]         o_count;

    int mismatches;
    int outstanding;
    int held;
    int replies;
    int full_hits;
    int bounds_hits;
    bit sender_quiet = 1'b0;

    indexed_array_store #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_index      (i_index),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_count      (o_count)
    );

    array_store_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_op          (i_op),
        .i_index       (i_index),
        .i_value       (i_value),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_status      (o_status),
        .i_read_value  (o_read_value),
        .i_count       (o_count),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_held        (held),
        .o_replies     (replies),
        .o_full_hits   (full_hits),
        .o_bounds_hits (bounds_hits)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // data with the sign and all-ones extremes mixed in
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // offer one word and hold it until the block takes it
    task automatic send_word(input logic [2:0] op, input logic [4:0] idx,
                             input logic [31:0] val);
        int gap;
        gap = sender_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_index <= idx;
        i_value <= val;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // receiver: random stalls, quiet stretches and one long hold-off
    initial begin : receiver
        int on_len;
        int gap;
        int round;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        for (round = 0; ; round++) begin
            i_ready <= 1'b1;
            on_len = $urandom_range(1, 12);
            repeat (on_len) @(posedge i_clk);
            if (round == 150) begin
                // long hold-off so the block backs up and stalls its input
                gap = 400;
            end else if ((round / 40) % 3 == 2) begin
                gap = 0;
            end else begin
                gap = pick_gap();
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int         n;
        int         r;
        bit         growing;
        logic [2:0] op;
        logic [4:0] idx;

        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_op    <= OP_PUSH;
        i_index <= '0;
        i_value <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store refusals
        send_word(OP_POP,    5'd0,  32'h0000_0000);
        send_word(OP_GET,    5'd0,  32'h0000_0000);
        send_word(OP_SET,    5'd0,  32'h1111_1111);
        send_word(OP_INSERT, 5'd1,  32'h2222_2222);
        // directed: build up with extreme data, insert at front, end and middle
        send_word(OP_INSERT, 5'd0,  32'h8000_0000);
        send_word(OP_PUSH,   5'd31, 32'h7fff_ffff);
        send_word(OP_PUSH,   5'd0,  32'h0000_0000);
        send_word(OP_PUSH,   5'd0,  32'hffff_ffff);
        send_word(OP_INSERT, 5'd4,  32'h1234_5678);
        send_word(OP_INSERT, 5'd1,  32'ha5a5_a5a5);
        // directed: reads and writes inside and past the count
        send_word(OP_GET,    5'd0,  32'hffff_ffff);
        send_word(OP_GET,    5'd5,  32'h0000_0000);
        send_word(OP_GET,    5'd6,  32'h0000_0000);
        send_word(OP_GET,    5'd31, 32'h0000_0000);
        send_word(OP_SET,    5'd2,  32'h5a5a_5a5a);
        send_word(OP_SET,    5'd31, 32'h7fff_ffff);
        send_word(OP_SPARE_5, 5'd0, 32'hffff_ffff);
        send_word(OP_SPARE_6, 5'd3, 32'h0000_0001);
        send_word(OP_SPARE_7, 5'd31, 32'h8000_0000);
        send_word(OP_INSERT, 5'd31, 32'h0f0f_0f0f);
        send_word(OP_GET,    5'd2,  32'h0000_0000);
        send_word(OP_POP,    5'd0,  32'h0000_0000);
        send_word(OP_POP,    5'd0,  32'h0000_0000);

        // random: swing between filling to the top and draining to empty
        growing = 1'b1;
        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2) begin
                // pause until every reply is back
                i_valid <= 1'b0;
                do @(posedge i_clk); while (outstanding != 0);
            end
            sender_quiet = ((n / 100) % 4 == 3);
            if (growing && held >= DEPTH && $urandom_range(0, 3) == 0) begin
                growing = 1'b0;
            end else if (!growing && held == 0 && $urandom_range(0, 3) == 0) begin
                growing = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (growing) begin
                if (r < 35)      op = OP_PUSH;
                else if (r < 65) op = OP_INSERT;
                else if (r < 80) op = OP_GET;
                else if (r < 90) op = OP_SET;
                else if (r < 97) op = OP_POP;
                else             op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
            end else begin
                if (r < 45)      op = OP_POP;
                else if (r < 65) op = OP_GET;
                else if (r < 80) op = OP_SET;
                else if (r < 88) op = OP_PUSH;
                else if (r < 96) op = OP_INSERT;
                else             op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
            end
            // aim the index mostly at the live range and its edge
            r = $urandom_range(0, 99);
            if (r < 65)      idx = 5'($urandom_range(0, held));
            else if (r < 80) idx = 5'(held);
            else             idx = 5'($urandom_range(0, 31));
            send_word(op, idx, pick_value());
        end

        // drain
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (40) @(posedge i_clk);

        $display("run covered %0d reply words, %0d refused as full, %0d refused as out of bounds",
                 replies, full_hits, bounds_hits);
        $display("directed edge cases, random fill and drain swings, one long output stall");
        if (mismatches == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
